// File: hdl/tbt_pkg.sv
// Shared constants for the thermistor Beta temperature block.
package tbt_pkg;

    localparam int ADC_BITS_DEF           = 12;
    localparam int SAMPLES_PER_RESULT_DEF = 10;

    localparam logic [15:0] T0_RESET   = 16'd29815;
    localparam logic [13:0] BETA_RESET = 14'd3950;

    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [15:0] KELVIN_OFS  = 16'd27310;
    localparam logic [53:0] TC_HOT_LIM  = 54'd57310;
    localparam logic [53:0] TC_COLD_LIM = 54'd17310;
    localparam logic [15:0] TEMP_MAX    = 16'sd30000;
    localparam logic [15:0] TEMP_MIN    = -16'sd10000;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_RAIL = 2'd2;

    localparam logic REG_T0   = 1'b0;
    localparam logic REG_BETA = 1'b1;

    typedef enum logic [10:0] {
        S_ACC  = 11'b00000000001,
        S_AVG  = 11'b00000000010,
        S_CHK  = 11'b00000000100,
        S_NORM = 11'b00000001000,
        S_SQ   = 11'b00000010000,
        S_LNQ  = 11'b00000100000,
        S_MULA = 11'b00001000000,
        S_MULB = 11'b00010000000,
        S_DSET = 11'b00100000000,
        S_DIV  = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } t_state;

endpackage

// File: hdl/thermistor_beta_temperature_top.sv
// Thermistor Beta temperature: sample averaging, log, Beta equation, saturation.
//
// Samples are taken one per cycle while the block is accumulating. Every
// SAMPLES_PER_RESULT samples the sum is divided bit-serially by the sample
// count (one bit per cycle). A range check on the average follows; then ln
// of F-avg and of avg are formed in turn by a shift normalizer, a squaring
// loop and a scaling step. Two constant-time products and a setup step then
// build the Beta equation terms. A restoring divider returns the temperature
// one quotient bit per cycle. After the last sample of a group the input
// stalls until the result is written, and also while the previous result
// word is still held on the output. A rail fault skips the log and the
// divider. The other samples are taken without stall.
module thermistor_beta_temperature_top
    import tbt_pkg::*;
#(
    parameter int ADC_BITS           = ADC_BITS_DEF,
    parameter int SAMPLES_PER_RESULT = SAMPLES_PER_RESULT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] temperature_centi, [27:16] average,
                                          // [29:28] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(SAMPLES_PER_RESULT + 1);
    localparam int SUM_W = ADC_BITS + CNT_W;
    localparam logic [15:0] FULL = 16'((32'd1 << ADC_BITS) - 32'd1);

    t_state             r_state;
    logic [15:0]        r_t0;
    logic [13:0]        r_beta;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_rem;
    logic [5:0]         r_step;
    logic [15:0]        r_avg;
    logic               r_rail;
    logic               r_hot;
    logic               r_pass;
    logic [31:0]        r_m;
    logic [3:0]         r_p;
    logic [15:0]        r_frac;
    logic [20:0]        r_lna;
    logic signed [20:0] r_l;
    logic [29:0]        r_p1;
    logic signed [37:0] r_tl;
    logic [53:0]        r_num;
    logic signed [38:0] r_den;
    logic [37:0]        r_drem;
    logic               r_out_valid;
    logic [31:0]        r_out;

    logic [15:0]      w_samp;
    logic [SUM_W-1:0] w_sum_nx;
    logic [CNT_W:0]   w_rem2;
    logic             w_ge;
    logic [15:0]      w_avg;
    logic [63:0]      w_sq;
    logic [32:0]      w_t;
    logic [49:0]      w_lprod;
    logic [20:0]      w_lnq;
    logic [36:0]      w_n;
    logic [20:0]      w_b100;
    logic [38:0]      w_drem2;
    logic             w_dge;
    logic             w_acc;
    logic             w_wr;

    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_BETA) ? {18'b0, r_beta} : {16'b0, r_t0};
    assign w_wr            = psel & penable & pwrite;
    assign o_s_axis_tready = (r_state == S_ACC);
    assign w_acc           = i_s_axis_tvalid & o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    assign w_samp   = {4'b0, i_s_axis_tdata[11:0]} & FULL;
    assign w_sum_nx = r_sum + SUM_W'(w_samp);
    assign w_rem2   = {r_rem, r_sum[SUM_W-1]};
    assign w_ge     = w_rem2 >= (CNT_W+1)'(SAMPLES_PER_RESULT);
    assign w_avg    = 16'(r_sum);
    assign w_sq     = 64'(r_m) * 64'(r_m);
    assign w_t      = w_sq[63:31];
    assign w_lprod  = 50'({r_p, r_frac}) * 50'(LN2_Q30) + 50'(32'd1 << 29);
    assign w_lnq    = w_lprod[50-1:30] == 20'b0 ? 21'b0 : 21'(w_lprod >> 30);
    assign w_n      = 37'(r_p1) * 37'd100;
    assign w_b100   = 21'({7'b0, r_beta}) * 21'd100;
    assign w_drem2  = {r_drem, r_num[53]};
    assign w_dge    = w_drem2 >= {1'b0, r_den[37:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_t0        <= T0_RESET;
            r_beta      <= BETA_RESET;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr) begin
                if (paddr[2] == REG_T0) begin
                    r_t0 <= pwdata[15:0];
                end else begin
                    r_beta <= pwdata[13:0];
                end
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_ACC: begin
                    if (w_acc) begin
                        r_sum <= w_sum_nx;
                        if (r_cnt == CNT_W'(SAMPLES_PER_RESULT - 1)) begin
                            r_cnt   <= '0;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= S_AVG;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end
                S_AVG: begin
                    r_rem  <= w_ge ? CNT_W'(w_rem2 - (CNT_W+1)'(SAMPLES_PER_RESULT))
                                   : CNT_W'(w_rem2);
                    r_sum  <= {r_sum[SUM_W-2:0], w_ge};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(SUM_W - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_avg <= w_avg;
                    r_sum <= '0;
                    r_hot <= 1'b0;
                    if (w_avg == 16'd0 || w_avg >= FULL) begin
                        r_rail  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_rail  <= 1'b0;
                        r_pass  <= 1'b0;
                        r_m     <= {FULL - w_avg, 16'b0};
                        r_p     <= 4'd15;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_m[31]) begin
                        r_step  <= '0;
                        r_frac  <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_m <= {r_m[30:0], 1'b0};
                        r_p <= r_p - 4'd1;
                    end
                end
                S_SQ: begin
                    r_m    <= w_t[32] ? w_t[32:1] : w_t[31:0];
                    r_frac <= {r_frac[14:0], w_t[32]};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd15) begin
                        r_state <= S_LNQ;
                    end
                end
                S_LNQ: begin
                    if (!r_pass) begin
                        r_lna   <= w_lnq;
                        r_pass  <= 1'b1;
                        r_m     <= {r_avg, 16'b0};
                        r_p     <= 4'd15;
                        r_state <= S_NORM;
                    end else begin
                        r_l     <= $signed(r_lna) - $signed(w_lnq);
                        r_state <= S_MULA;
                    end
                end
                S_MULA: begin
                    r_p1    <= 30'(r_t0) * 30'(r_beta);
                    r_tl    <= $signed({1'b0, r_t0}) * r_l;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_num   <= {1'b0, w_n, 16'h0};
                    r_den   <= $signed({2'b00, w_b100, 16'h0}) + 39'(r_tl);
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    if (r_den[38] || r_den == 39'sd0) begin
                        r_hot   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_num   <= r_num + {16'b0, r_den[38:1]};
                        r_drem  <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_drem <= w_dge ? 38'(w_drem2 - {1'b0, r_den[37:0]}) : 38'(w_drem2);
                    r_num  <= {r_num[52:0], w_dge};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd53) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid) begin
                        r_out_valid        <= 1'b1;
                        r_out[31:30]       <= 2'b00;
                        r_out[27:16]       <= r_avg[11:0];
                        r_state            <= S_ACC;
                        priority if (r_rail) begin
                            r_out[15:0]  <= 16'd0;
                            r_out[29:28] <= ST_RAIL;
                        end else if (r_hot || r_num > TC_HOT_LIM) begin
                            r_out[15:0]  <= TEMP_MAX;
                            r_out[29:28] <= ST_SAT;
                        end else if (r_num < TC_COLD_LIM) begin
                            r_out[15:0]  <= TEMP_MIN;
                            r_out[29:28] <= ST_SAT;
                        end else begin
                            r_out[15:0]  <= r_num[15:0] - KELVIN_OFS;
                            r_out[29:28] <= ST_OK;
                        end
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

endmodule

// File: tb/sv/thermistor_beta_temperature_top_tb.sv
// Self-checking testbench for the thermistor Beta temperature block.
module thermistor_beta_temperature_top_tb;
    import tbt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GROUP = SAMPLES_PER_RESULT_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] average;
        logic [15:0] temp_centi;
    } reading_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [11:0] sample_queue[$];
    reading_t    reading_queue[$];
    logic [15:0] t0_model;
    logic [13:0] beta_model;
    logic [31:0] sum_model;
    int          count_model;
    int          errors = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;

    thermistor_beta_temperature_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint ln_q16(input logic [31:0] x);
        int          p;
        logic [63:0] m;
        logic [15:0] frac;
        logic [63:0] l2;
        p = 0;
        frac = '0;
        if (x == 0) return 0;
        while (p < 31 && (x >> (p + 1)) != 0) p++;
        m = 64'(x) << (31 - p);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        l2 = (64'(p) << 16) | 64'(frac);
        return longint'((l2 * 64'd744261118 + (64'd1 << 29)) >> 30);
    endfunction

    task automatic predict_sample(input logic [11:0] smp);
        reading_t r;
        logic [31:0] avg;
        longint lq, num, den, tc, temp;
        sum_model += 32'(smp);
        count_model++;
        if (count_model < GROUP) return;
        avg = sum_model / GROUP;
        sum_model = 0;
        count_model = 0;
        r.average = avg[11:0];
        r.status = ST_OK;
        temp = 0;
        if (avg == 0 || avg >= 4095) begin
            r.status = ST_RAIL;
        end else begin
            lq = ln_q16(4095 - avg) - ln_q16(avg);
            num = 100 * longint'(t0_model) * longint'(beta_model) * 65536;
            den = 100 * longint'(beta_model) * 65536 + longint'(t0_model) * lq;
            if (den <= 0) begin
                temp = 30000;
                r.status = ST_SAT;
            end else begin
                tc = (num + den / 2) / den;
                temp = tc - 27310;
                if (temp > 30000) begin
                    temp = 30000;
                    r.status = ST_SAT;
                end else if (temp < -10000) begin
                    temp = -10000;
                    r.status = ST_SAT;
                end
            end
        end
        r.temp_centi = temp[15:0];
        reading_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            predict_sample(s_tdata[11:0]);
        end
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
            s_tvalid <= 1'b1;
            s_tdata <= {4'd0, sample_queue.pop_front()};
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 30);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        reading_t got, want;
        if (m_tvalid && m_tready) begin
            got = m_tdata[29:0];
            if (reading_queue.size() == 0) begin
                $error("result with none expected: %h", m_tdata);
                errors++;
            end else begin
                want = reading_queue.pop_front();
                if (got.temp_centi !== want.temp_centi) begin
                    $error("temperature_centi exp %0d got %0d",
                           $signed(want.temp_centi), $signed(got.temp_centi));
                    errors++;
                end
                if (got.average !== want.average) begin
                    $error("average exp %0d got %0d", want.average, got.average);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("thermistor_beta_temperature_top_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'd0) t0_model = value[15:0];
        else if (addr == 3'd4) beta_model = value[13:0];
    endtask

    task automatic push_group(input logic [11:0] lvl, input bit noisy);
        for (int i = 0; i < GROUP; i++) begin
            if (noisy) sample_queue.push_back(12'($urandom_range(0, 4095)));
            else sample_queue.push_back(lvl);
        end
    endtask

    task automatic drain;
        while (sample_queue.size() > 0 || s_tvalid || reading_queue.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        logic [11:0] lvl;
        t0_model = T0_RESET;
        beta_model = BETA_RESET;
        sum_model = 0;
        count_model = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        push_group(12'd0, 0);
        push_group(12'd4095, 0);
        push_group(12'd4094, 0);
        push_group(12'd1, 0);
        sample_queue.push_back(12'hAAA);
        sample_queue.push_back(12'h555);
        for (int i = 0; i < 8; i++) sample_queue.push_back(12'd2048);
        push_group(12'd2047, 0);
        drain();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(3'd0, 32'd20000); write_reg(3'd4, 32'd1000); end
                1: begin write_reg(3'd0, 32'd40000); write_reg(3'd4, 32'd10000); end
                2: begin write_reg(3'd0, 32'd40000); write_reg(3'd4, 32'd1000); end
                3: begin write_reg(3'd0, 32'd20000); write_reg(3'd4, 32'd10000); end
                4: begin
                    write_reg(3'd0, 32'($urandom_range(20000, 40000)));
                    write_reg(3'd4, 32'($urandom_range(1000, 10000)));
                end
                default: begin write_reg(3'd0, 32'hFFFF_FFFF); write_reg(3'd4, 32'hFFFF_FFFF); end
            endcase
            for (int g = 0; g < 22; g++) begin
                lvl = 12'($urandom_range(0, 4095));
                if ($urandom_range(0, 3) == 0) push_group(lvl, 1);
                else if ($urandom_range(0, 7) == 0) push_group(12'($urandom_range(0, 3)), 0);
                else push_group(lvl, 0);
            end
            drain();
        end
        if (errors == 0) begin
            $display("thermistor_beta_temperature_top_tb passed");
        end else begin
            $display("thermistor_beta_temperature_top_tb failed");
        end
        $finish;
    end
endmodule
